/* sv/vn_pkg.sv */
package vn_pkg;

    // Number of component fields carried on each beat.
    localparam int FIELD_COUNT = 4;
    // Default limit on the number of components that take part.
    localparam int MAX_COMPONENTS_DEF = 4;
    // Reset value of the component count register.
    localparam logic [2:0] DIMS_RESET = 3'd3;
    // Register byte address of the component count register.
    localparam logic [2:0] ADDR_DIMS = 3'd0;

    // Widths of the arithmetic.
    localparam int MAG_W = 16;
    localparam int SQ_W = 2 * MAG_W;
    localparam int SUM_W = SQ_W + 1;
    localparam int LEN_W = 17;
    localparam int SQRT_STEPS = 17;
    localparam int Q_BITS = 15;
    localparam int REM_W = 31;
    localparam logic [Q_BITS-1:0] ONE_Q14 = 15'd16384;

    // Input beat.
    typedef struct packed {
        logic signed [15:0] comp_3;
        logic signed [15:0] comp_2;
        logic signed [15:0] comp_1;
        logic signed [15:0] comp_0;
    } t_in;

    // Result beat.
    typedef struct packed {
        logic signed [15:0] unit_3;
        logic signed [15:0] unit_2;
        logic signed [15:0] unit_1;
        logic signed [15:0] unit_0;
    } t_out;

    // Classified item handed from the front part to the back part.
    typedef struct packed {
        logic [FIELD_COUNT-1:0][MAG_W-1:0] mag;
        logic [FIELD_COUNT-1:0]            neg;
        logic [LEN_W-1:0]                  len;
    } t_item;

endpackage

/* sv/vn_front.sv */
module vn_front #(
    parameter int MAX_COMPONENTS = vn_pkg::MAX_COMPONENTS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  vn_pkg::t_in    i_comp,
    input  logic [2:0]     i_dims,
    input  logic           i_full,
    output logic           o_stall,
    output logic           o_push,
    output vn_pkg::t_item  o_item
);

    localparam int LIM = (MAX_COMPONENTS < vn_pkg::FIELD_COUNT) ?
                         MAX_COMPONENTS : vn_pkg::FIELD_COUNT;
    localparam int NS = vn_pkg::SQRT_STEPS;
    localparam int FC = vn_pkg::FIELD_COUNT;
    localparam int RW = vn_pkg::SUM_W + 1;

    logic [3:0] w_n;
    logic       w_en;
    logic [FC-1:0][15:0] w_raw;

    logic                              r_a_valid;
    logic [FC-1:0][vn_pkg::MAG_W-1:0]  r_a_mag;
    logic [FC-1:0]                     r_a_neg;
    logic                              r_b_valid;
    logic [FC-1:0][vn_pkg::SQ_W-1:0]   r_b_sq;
    logic [FC-1:0][vn_pkg::MAG_W-1:0]  r_b_mag;
    logic [FC-1:0]                     r_b_neg;
    logic                              r_c_valid;
    logic [vn_pkg::SUM_W-1:0]          r_c_sum;
    logic [FC-1:0][vn_pkg::MAG_W-1:0]  r_c_mag;
    logic [FC-1:0]                     r_c_neg;

    logic [NS-1:0]                              r_s_valid;
    logic [NS-1:0][vn_pkg::SUM_W-1:0]           r_s_x;
    logic [NS-1:0][RW-1:0]                      r_s_root;
    logic [NS-1:0][FC-1:0][vn_pkg::MAG_W-1:0]   r_s_mag;
    logic [NS-1:0][FC-1:0]                      r_s_neg;
    logic [NS-1:0][vn_pkg::SUM_W-1:0]           n_s_x;
    logic [NS-1:0][RW-1:0]                      n_s_root;

    // The whole front part holds while its last stage cannot enter the queue.
    assign w_en    = !(r_s_valid[NS-1] && i_full);
    assign o_stall = !w_en;
    assign o_push  = r_s_valid[NS-1] && !i_full;
    assign w_raw   = {i_comp.comp_3, i_comp.comp_2, i_comp.comp_1, i_comp.comp_0};

    // Clamp the component count into one up to the limit.
    always_comb begin
        if (i_dims == 3'd0) begin
            w_n = 4'd1;
        end else if (int'(i_dims) > LIM) begin
            w_n = 4'(LIM);
        end else begin
            w_n = {1'b0, i_dims};
        end
    end

    // One restoring square root step per stage; the trial bit is fixed per stage.
    always_comb begin
        logic [vn_pkg::SUM_W-1:0] x_in;
        logic [RW-1:0]            root_in;
        logic [RW-1:0]            bitv;
        logic [RW-1:0]            trial;
        for (int j = 0; j < NS; j++) begin
            x_in    = (j == 0) ? r_c_sum : r_s_x[(j == 0) ? 0 : j-1];
            root_in = (j == 0) ? '0 : r_s_root[(j == 0) ? 0 : j-1];
            bitv    = RW'(1) << (2 * (NS - 1 - j));
            trial   = root_in + bitv;
            if ({1'b0, x_in} >= trial) begin
                n_s_x[j]    = x_in - trial[vn_pkg::SUM_W-1:0];
                n_s_root[j] = (root_in >> 1) + bitv;
            end else begin
                n_s_x[j]    = x_in;
                n_s_root[j] = root_in >> 1;
            end
        end
    end

    // Valid bits of the front pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_s_valid <= '0;
        end else if (w_en) begin
            r_a_valid <= i_take;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_s_valid <= {r_s_valid[NS-2:0], r_c_valid};
        end
    end

    // Payload of the front pipeline: magnitudes, squares, sum, root steps.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < FC; i++) begin
                r_a_neg[i] <= w_raw[i][15];
                if (i < int'(w_n)) begin
                    r_a_mag[i] <= w_raw[i][15] ? 16'(-w_raw[i]) : w_raw[i];
                end else begin
                    r_a_mag[i] <= '0;
                end
                r_b_sq[i] <= r_a_mag[i] * r_a_mag[i];
            end
            r_b_mag <= r_a_mag;
            r_b_neg <= r_a_neg;
            r_c_sum <= ({1'b0, r_b_sq[0]} + {1'b0, r_b_sq[1]})
                     + ({1'b0, r_b_sq[2]} + {1'b0, r_b_sq[3]});
            r_c_mag <= r_b_mag;
            r_c_neg <= r_b_neg;
            for (int j = 0; j < NS; j++) begin
                r_s_x[j]    <= n_s_x[j];
                r_s_root[j] <= n_s_root[j];
                r_s_mag[j]  <= (j == 0) ? r_c_mag : r_s_mag[(j == 0) ? 0 : j-1];
                r_s_neg[j]  <= (j == 0) ? r_c_neg : r_s_neg[(j == 0) ? 0 : j-1];
            end
        end
    end

    // A zero length divides by one.
    always_comb begin
        o_item.mag = r_s_mag[NS-1];
        o_item.neg = r_s_neg[NS-1];
        if (r_s_root[NS-1] == '0) begin
            o_item.len = vn_pkg::LEN_W'(1);
        end else begin
            o_item.len = r_s_root[NS-1][vn_pkg::LEN_W-1:0];
        end
    end

endmodule

/* sv/vn_queue.sv */
module vn_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  vn_pkg::t_item  i_item,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output vn_pkg::t_item  o_item
);

    localparam int DEPTH = 2;

    vn_pkg::t_item   r_mem [DEPTH];
    logic            r_wr;
    logic            r_rd;
    logic [1:0]      r_cnt;
    logic            w_push;
    logic            w_pop;

    assign o_full  = (r_cnt == 2'(DEPTH));
    assign o_empty = (r_cnt == 2'd0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_item  = r_mem[r_rd];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr <= !r_wr;
            end
            if (w_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

/* sv/vn_back.sv */
module vn_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  vn_pkg::t_item  i_item,
    output logic           o_pop,
    output logic           o_valid,
    output vn_pkg::t_out   o_unit
);

    localparam int NQ = vn_pkg::Q_BITS;
    localparam int FC = vn_pkg::FIELD_COUNT;
    localparam int RW = vn_pkg::REM_W;

    logic [NQ-1:0]                    r_d_valid;
    logic [NQ-1:0][FC-1:0][RW-1:0]    r_d_rem;
    logic [NQ-1:0][FC-1:0][NQ-1:0]    r_d_q;
    logic [NQ-1:0][vn_pkg::LEN_W-1:0] r_d_len;
    logic [NQ-1:0][FC-1:0]            r_d_neg;
    logic [NQ-1:0][FC-1:0][RW-1:0]    n_d_rem;
    logic [NQ-1:0][FC-1:0][NQ-1:0]    n_d_q;
    logic                             r_valid;
    vn_pkg::t_out                     r_unit;
    logic [FC-1:0][15:0]              w_res;

    // The back part never holds, so it takes the queue head whenever there is one.
    assign o_pop = !i_empty;

    // One quotient bit per stage for each of the four lanes.
    always_comb begin
        logic [RW-1:0]            rem_in;
        logic [NQ-1:0]            q_in;
        logic [vn_pkg::LEN_W-1:0] len_in;
        logic [RW-1:0]            dsh;
        for (int j = 0; j < NQ; j++) begin
            for (int i = 0; i < FC; i++) begin
                if (j == 0) begin
                    rem_in = RW'(i_item.mag[i]) << (NQ - 1);
                    q_in   = '0;
                    len_in = i_item.len;
                end else begin
                    rem_in = r_d_rem[(j == 0) ? 0 : j-1][i];
                    q_in   = r_d_q[(j == 0) ? 0 : j-1][i];
                    len_in = r_d_len[(j == 0) ? 0 : j-1];
                end
                dsh = RW'(len_in) << (NQ - 1 - j);
                if (rem_in >= dsh) begin
                    n_d_rem[j][i] = rem_in - dsh;
                    n_d_q[j][i]   = q_in | (NQ'(1) << (NQ - 1 - j));
                end else begin
                    n_d_rem[j][i] = rem_in;
                    n_d_q[j][i]   = q_in;
                end
            end
        end
    end

    // Divider stage valid bits and the result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_d_valid <= {r_d_valid[NQ-2:0], o_pop};
            r_valid   <= r_d_valid[NQ-1];
        end
    end

    // Divider stage payload.
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < NQ; j++) begin
            r_d_rem[j] <= n_d_rem[j];
            r_d_q[j]   <= n_d_q[j];
            r_d_len[j] <= (j == 0) ? i_item.len : r_d_len[(j == 0) ? 0 : j-1];
            r_d_neg[j] <= (j == 0) ? i_item.neg : r_d_neg[(j == 0) ? 0 : j-1];
        end
    end

    // Saturate to one and restore the sign.
    always_comb begin
        logic [NQ-1:0] q;
        for (int i = 0; i < FC; i++) begin
            q = r_d_q[NQ-1][i];
            if (q > vn_pkg::ONE_Q14) begin
                q = vn_pkg::ONE_Q14;
            end
            w_res[i] = r_d_neg[NQ-1][i] ? 16'(-{1'b0, q}) : {1'b0, q};
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        r_unit.unit_0 <= w_res[0];
        r_unit.unit_1 <= w_res[1];
        r_unit.unit_2 <= w_res[2];
        r_unit.unit_3 <= w_res[3];
    end

    assign o_valid = r_valid;
    assign o_unit  = r_unit;

endmodule

/* sv/vector_normalize_core.sv */
// An accepted start reaches the o_valid strobe through 20 front stages
// (magnitude, square, sum, a 17-step square root), the queue, 15 divider stages
// and the output register. Throughput: one beat per cycle, set by the fully pipelined
// root and divider. The receiver cannot stall, so busy stays low in operation.
// Reset (synchronous, active low) empties the pipelines and queue and sets the
// component count register to 3.
module vector_normalize_core #(
    parameter int MAX_COMPONENTS = vn_pkg::MAX_COMPONENTS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  vn_pkg::t_in   i_comp,
    output logic          o_valid,
    output vn_pkg::t_out  o_unit,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic          w_dims_wr;
    logic [2:0]    r_dims_val;
    logic          w_stall;
    logic          w_push;
    logic          w_full;
    logic          w_empty;
    logic          w_pop;
    vn_pkg::t_item w_front_item;
    vn_pkg::t_item w_head;

    assign pready = 1'b1;
    assign busy   = w_stall;
    assign prdata = {29'd0, r_dims_val};

    // Component count register; only address bit 2 is decoded, the low address bits are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims_val <= vn_pkg::DIMS_RESET;
        end else if (w_dims_wr) begin
            r_dims_val <= pwdata[2:0];
        end
    end

    assign w_dims_wr = psel && penable && pwrite && pready
                    && (paddr[2] == vn_pkg::ADDR_DIMS[2]);

    vn_front #(
        .MAX_COMPONENTS(MAX_COMPONENTS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (start && !w_stall),
        .i_comp  (i_comp),
        .i_dims  (r_dims_val),
        .i_full  (w_full),
        .o_stall (w_stall),
        .o_push  (w_push),
        .o_item  (w_front_item)
    );

    vn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_item  (w_head)
    );

    vn_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_item  (w_head),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .o_unit  (o_unit)
    );

endmodule
